// ===== hw/rtl/lge_pkg.sv =====
// Package for the Life generation engine: field widths, stream packing and
// command codes shared by the RTL.
// No dependencies.
package lge_pkg;

    localparam int DEF_GRID_SIDE = 64;

    localparam int CMD_W         = 2;
    localparam int COORD_FIELD_W = 6;

    localparam int COL_LSB       = 0;
    localparam int ROW_LSB       = COL_LSB + COORD_FIELD_W;
    localparam int ALIVE_LSB     = ROW_LSB + COORD_FIELD_W;

    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 8;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_WRITE = 2'd0;
    localparam cmd_t CMD_READ  = 2'd1;
    localparam cmd_t CMD_STEP  = 2'd2;

endpackage

// ===== hw/rtl/life_generation_engine.sv =====
// Life generation engine top level: toroidal Conway's Life grid held as
// two row-wide banks of synchronous memory, with single-cell access.
// Depends on lge_pkg.
//
// Usage:
//   s_ channel carries one command per transfer: write a cell, read a cell
//   or advance one generation (s_tuser = command, s_tdata = col/row/alive).
//   m_ channel returns exactly one transfer per command: the read value in
//   m_tdata[0] (0 for other commands) and the command echoed on m_tuser.
//   Commands are handled one at a time. A cell write is a read-modify-write
//   of one grid row of the current bank; a cell read reads that one row.
//   A generation streams the GRID_SIDE rows of the current bank through a
//   three-row window (one row read per cycle) and writes each new row to the
//   other bank, which then becomes current. An unused command code or a cell
//   outside the grid goes straight to the response. Throughput is set by the
//   single read port of the row memory.
//   After reset a clearing pass zeroes every row of both banks; s_tready
//   stays low until it ends. Bank a is then current.
//   The result sits in an output register; if the receiver stalls, the
//   engine holds the next result until the register is free.
module life_generation_engine #(
    parameter int GRID_SIDE = lge_pkg::DEF_GRID_SIDE
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [5:0] col, [11:6] row, [12] alive, [15:13] zero
    input  logic [lge_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  logic [lge_pkg::CMD_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] cell_value, [7:1] zero
    output logic [lge_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] done_cmd
    output logic [lge_pkg::CMD_W-1:0]     m_tuser
);
    import lge_pkg::*;

    localparam int CW    = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int CNT_W = CW + 1;
    localparam int EXT_W = (CW + 1 > COORD_FIELD_W) ? CW + 1 : COORD_FIELD_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_GEN   = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;

    typedef logic [GRID_SIDE-1:0] row_t;

    // grid memories, one row per entry
    row_t bank_a_mem [GRID_SIDE];
    row_t bank_b_mem [GRID_SIDE];

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             cur_bank_reg, cur_bank_next;

    cmd_t             cmd_reg, cmd_next;
    logic [CW-1:0]    col_idx_reg, col_idx_next;
    logic [CW-1:0]    row_idx_reg, row_idx_next;
    logic             alive_reg, alive_next;
    logic             inside_reg, inside_next;
    logic             res_val_reg, res_val_next;

    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             rdv_reg;
    logic [CNT_W-1:0] rdk_reg;
    logic             winv_reg;
    logic [CNT_W-1:0] winj_reg;
    row_t             top_reg, mid_reg, bot_reg;

    row_t             rd_a_reg, rd_b_reg;
    logic [CW-1:0]    rd_addr;
    logic             wr_a, wr_b;
    logic [CW-1:0]    wr_addr;
    row_t             wr_data;

    logic             m_tvalid_reg;
    logic             m_val_reg;
    cmd_t             m_cmd_reg;

    cmd_t             in_cmd;
    logic [EXT_W-1:0] in_col_ext, in_row_ext;
    logic             in_inside;
    logic             s_xfer;
    logic             rd_issue;
    logic [CW-1:0]    gen_rd_row;
    logic             gen_wr, gen_last;
    row_t             cur_row, mod_row, next_row;
    logic             out_load;

    // input unpacking
    assign in_cmd     = s_tuser;
    assign in_col_ext = EXT_W'(s_tdata[COL_LSB +: COORD_FIELD_W]);
    assign in_row_ext = EXT_W'(s_tdata[ROW_LSB +: COORD_FIELD_W]);
    assign in_inside  = (in_col_ext < EXT_W'(GRID_SIDE)) && (in_row_ext < EXT_W'(GRID_SIDE));

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    // generation read sequence: row SIDE-1, 0, 1, ..., SIDE-1, 0
    assign rd_issue = (state_reg == ST_GEN) && (rd_cnt_reg <= CNT_W'(GRID_SIDE + 1));
    always_comb begin
        if (rd_cnt_reg == '0) begin
            gen_rd_row = CW'(GRID_SIDE - 1);
        end else if (rd_cnt_reg == CNT_W'(GRID_SIDE + 1)) begin
            gen_rd_row = '0;
        end else begin
            gen_rd_row = CW'(rd_cnt_reg - CNT_W'(1));
        end
    end

    assign gen_wr   = winv_reg && (winj_reg >= CNT_W'(2));
    assign gen_last = winv_reg && (winj_reg == CNT_W'(GRID_SIDE + 1));

    // new generation of the centre window row
    for (genvar c = 0; c < GRID_SIDE; c++) begin : g_cell
        localparam int LC = (c == 0) ? GRID_SIDE - 1 : c - 1;
        localparam int RC = (c == GRID_SIDE - 1) ? 0 : c + 1;
        logic [3:0] nb;
        assign nb = 4'(top_reg[LC]) + 4'(top_reg[c]) + 4'(top_reg[RC])
                  + 4'(mid_reg[LC]) + 4'(mid_reg[RC])
                  + 4'(bot_reg[LC]) + 4'(bot_reg[c]) + 4'(bot_reg[RC]);
        assign next_row[c] = (nb == 4'd3) || (mid_reg[c] && (nb == 4'd2));
    end

    assign cur_row = cur_bank_reg ? rd_b_reg : rd_a_reg;

    always_comb begin
        mod_row              = cur_row;
        mod_row[col_idx_reg] = alive_reg;
    end

    // memory port muxing
    always_comb begin
        rd_addr = (state_reg == ST_GEN) ? gen_rd_row : in_row_ext[CW-1:0];
        wr_a    = 1'b0;
        wr_b    = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (state_reg == ST_CLEAR) begin
            wr_a    = 1'b1;
            wr_b    = 1'b1;
            wr_addr = clr_cnt_reg;
        end else if (state_reg == ST_ACC && cmd_reg == CMD_WRITE) begin
            wr_a    = !cur_bank_reg;
            wr_b    = cur_bank_reg;
            wr_addr = row_idx_reg;
            wr_data = mod_row;
        end else if (gen_wr) begin
            wr_a    = cur_bank_reg;
            wr_b    = !cur_bank_reg;
            wr_addr = CW'(winj_reg - CNT_W'(2));
            wr_data = next_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_a) begin
            bank_a_mem[wr_addr] <= wr_data;
        end
        if (wr_b) begin
            bank_b_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= bank_a_mem[rd_addr];
        rd_b_reg <= bank_b_mem[rd_addr];
    end

    assign out_load = (state_reg == ST_RESP) && (!m_tvalid_reg || m_tready);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        cur_bank_next = cur_bank_reg;
        cmd_next      = cmd_reg;
        col_idx_next  = col_idx_reg;
        row_idx_next  = row_idx_reg;
        alive_next    = alive_reg;
        inside_next   = inside_reg;
        res_val_next  = res_val_reg;
        rd_cnt_next   = rd_issue ? rd_cnt_reg + CNT_W'(1) : rd_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CW'(GRID_SIDE - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_xfer) begin
                    cmd_next     = in_cmd;
                    col_idx_next = in_col_ext[CW-1:0];
                    row_idx_next = in_row_ext[CW-1:0];
                    alive_next   = s_tdata[ALIVE_LSB];
                    inside_next  = in_inside;
                    res_val_next = 1'b0;
                    rd_cnt_next  = '0;
                    if ((in_cmd == CMD_WRITE || in_cmd == CMD_READ) && in_inside) begin
                        state_next = ST_ACC;
                    end else if (in_cmd == CMD_STEP) begin
                        state_next = ST_GEN;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_ACC: begin
                if (cmd_reg == CMD_READ) begin
                    res_val_next = cur_row[col_idx_reg];
                end
                state_next = ST_RESP;
            end
            ST_GEN: begin
                if (gen_last) begin
                    cur_bank_next = !cur_bank_reg;
                    state_next    = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            cur_bank_reg <= 1'b0;
            rd_cnt_reg   <= '0;
            rdv_reg      <= 1'b0;
            winv_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            cur_bank_reg <= cur_bank_next;
            rd_cnt_reg   <= rd_cnt_next;
            rdv_reg      <= rd_issue;
            winv_reg     <= rdv_reg;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        col_idx_reg <= col_idx_next;
        row_idx_reg <= row_idx_next;
        alive_reg   <= alive_next;
        inside_reg  <= inside_next;
        res_val_reg <= res_val_next;
        rdk_reg     <= rd_cnt_reg;
        winj_reg    <= rdk_reg;
        if (rdv_reg) begin
            top_reg <= mid_reg;
            mid_reg <= bot_reg;
            bot_reg <= cur_bank_reg ? rd_b_reg : rd_a_reg;
        end
        if (out_load) begin
            m_val_reg <= res_val_reg && inside_reg && (cmd_reg == CMD_READ);
            m_cmd_reg <= cmd_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_val_reg);
    assign m_tuser  = m_cmd_reg;

    // checks
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_tready)
        else $error("transfer accepted while a command is in flight");

    a_value_only_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != CMD_READ) |-> (m_tdata[0] == 1'b0))
        else $error("cell value set on a non-read result");

    a_bank_swap: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(cur_bank_reg) |-> $past(gen_last))
        else $error("bank swap outside generation end");

    a_gen_write_in_gen: assert property (@(posedge aclk) disable iff (!aresetn)
        gen_wr |-> (state_reg == ST_GEN))
        else $error("generation row written outside a step");

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result loaded outside response state");

endmodule
